// ===== hw/rtl/ofp_pkg.sv =====
// ----------------------------------------------------------------------------
// ofp_pkg
// shared types and constants for the optical flow frame parser
// ----------------------------------------------------------------------------
package ofp_pkg;

    localparam int PAYLOAD_BYTES = 10;
    localparam int POS_W         = 4;

    typedef logic [POS_W-1:0] t_pos;

    localparam t_pos POS_HDR0  = t_pos'(0);
    localparam t_pos POS_HDR1  = t_pos'(1);
    localparam t_pos POS_PAY0  = t_pos'(2);
    localparam t_pos POS_CHECK = t_pos'(2 + PAYLOAD_BYTES);
    localparam t_pos POS_TAIL  = t_pos'(3 + PAYLOAD_BYTES);

    localparam logic [7:0] HDR_FIRST  = 8'hFE;
    localparam logic [7:0] HDR_SECOND = 8'h0A;
    localparam logic [7:0] TAIL_MARK  = 8'h55;

    typedef enum logic [1:0] {
        ST_GOOD = 2'd0,
        ST_CSUM = 2'd1,
        ST_TAIL = 2'd2
    } t_status;

    typedef struct packed {
        logic        emit;
        t_status     status;
        logic [15:0] flow_x;
        logic [15:0] flow_y;
        logic [15:0] span_us;
        logic [15:0] ground_dist;
        logic [7:0]  valid_code;
        logic [7:0]  version_code;
        logic        usable;
    } t_result;

endpackage

// ===== hw/rtl/ofp_in_stage.sv =====
// ----------------------------------------------------------------------------
// ofp_in_stage
// input register holding one received byte ahead of the parser
// ----------------------------------------------------------------------------
module ofp_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_stall = r_valid && !i_advance;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_byte <= i_rx_byte;
        end
    end

endmodule

// ===== hw/rtl/ofp_parser.sv =====
// ----------------------------------------------------------------------------
// ofp_parser
// frame position counter, payload store, running xor and result forming
// ----------------------------------------------------------------------------
module ofp_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [7:0]       i_byte,
    output ofp_pkg::t_result o_res
);
    import ofp_pkg::*;

    t_pos       r_pos;
    t_pos       n_pos;
    logic [7:0] r_xor;
    logic [7:0] n_xor;
    logic [7:0] r_store [PAYLOAD_BYTES];
    t_result    res;

    assign o_res = res;

    always_comb begin
        n_pos      = r_pos;
        n_xor      = r_xor;
        res        = '0;
        res.status = ST_GOOD;
        if (i_en) begin
            if (r_pos == POS_HDR0) begin
                if (i_byte == HDR_FIRST) begin
                    n_pos = POS_HDR1;
                    n_xor = '0;
                end
            end else if (r_pos == POS_HDR1) begin
                if (i_byte == HDR_SECOND) begin
                    n_pos = POS_PAY0;
                    n_xor = '0;
                end else begin
                    n_pos = POS_HDR0;
                end
            end else if (r_pos < POS_CHECK) begin
                n_xor = r_xor ^ i_byte;
                n_pos = r_pos + t_pos'(1);
            end else if (r_pos == POS_CHECK) begin
                if (r_xor != i_byte) begin
                    n_pos      = POS_HDR0;
                    res.emit   = 1'b1;
                    res.status = ST_CSUM;
                end else begin
                    n_pos = POS_TAIL;
                end
            end else begin
                n_pos    = POS_HDR0;
                res.emit = 1'b1;
                if (i_byte != TAIL_MARK) begin
                    res.status = ST_TAIL;
                end else begin
                    res.flow_x       = {r_store[1], r_store[0]};
                    res.flow_y       = {r_store[3], r_store[2]};
                    res.span_us      = {r_store[5], r_store[4]};
                    res.ground_dist  = {r_store[7], r_store[6]};
                    res.valid_code   = r_store[8];
                    res.version_code = r_store[9];
                    res.usable       = (r_store[8] != 8'd0);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= POS_HDR0;
            r_xor <= '0;
        end else begin
            r_pos <= n_pos;
            r_xor <= n_xor;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            if (i_en && r_pos == t_pos'(POS_PAY0 + i)) begin
                r_store[i] <= i_byte;
            end
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_TAIL)
        else $error("frame position out of range");

    a_emit_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.emit |-> (r_pos >= POS_CHECK))
        else $error("result outside check or tail position");

    a_emit_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && res.emit) |=> (r_pos == POS_HDR0))
        else $error("parser did not restart after result");

    a_hdr_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_en && r_pos == POS_HDR0 && i_byte == HDR_FIRST)
        |=> (r_pos == POS_HDR1 && r_xor == 8'd0))
        else $error("first header byte not taken");

endmodule

// ===== hw/rtl/ofp_out_stage.sv =====
// ----------------------------------------------------------------------------
// ofp_out_stage
// result register feeding the output channel
// ----------------------------------------------------------------------------
module ofp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ofp_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_advance,
    output logic             o_valid,
    output ofp_pkg::t_result o_res
);
    import ofp_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_advance = !r_valid || !i_stall;
    assign o_valid   = r_valid;
    assign o_res     = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_load && i_res.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_load && i_res.emit) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== hw/rtl/optical_flow_frame_parser.sv =====
// a frame's closing byte is parsed from the input register into the result register
// throughput: one byte per cycle; the input register, the parser and
// the result register all advance together whenever the result register is free
// reset: synchronous active low; clears the frame position, running xor and both
// valid flags; the payload store is not cleared
// ----------------------------------------------------------------------------
// optical_flow_frame_parser
// parses optical flow sensor frames from a received byte stream
// ----------------------------------------------------------------------------
module optical_flow_frame_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_rx_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [15:0] o_flow_x,
    output logic signed [15:0] o_flow_y,
    output logic [15:0]        o_span_us,
    output logic [15:0]        o_ground_dist,
    output logic [7:0]         o_valid_code,
    output logic [7:0]         o_version_code,
    output logic               o_usable
);
    import ofp_pkg::*;

    logic       advance;
    logic       in_valid;
    logic [7:0] in_byte;
    logic       parse_en;
    t_result    parse_res;
    t_result    out_res;

    assign parse_en = in_valid && advance;

    ofp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_rx_byte (i_rx_byte),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    ofp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (parse_en),
        .i_byte  (in_byte),
        .o_res   (parse_res)
    );

    ofp_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (in_valid),
        .i_res     (parse_res),
        .i_stall   (i_stall),
        .o_advance (advance),
        .o_valid   (o_valid),
        .o_res     (out_res)
    );

    assign o_status       = out_res.status;
    assign o_flow_x       = $signed(out_res.flow_x);
    assign o_flow_y       = $signed(out_res.flow_y);
    assign o_span_us      = out_res.span_us;
    assign o_ground_dist  = out_res.ground_dist;
    assign o_valid_code   = out_res.valid_code;
    assign o_version_code = out_res.version_code;
    assign o_usable       = out_res.usable;

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the optical flow frame parser. Header, payload,
// checksum and tail bytes are offered one item at a time, in bursts with
// random gaps, while the result side stalls on its own pattern. A frame
// predictor kept in the scoreboard tracks position, payload and running xor
// for every accepted byte, and each result is compared field by field with
// the oldest expected one.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ofp_pkg::*;

    localparam int ITEM_TARGET = 850;
    localparam int LONG_HOLD   = 300;
    localparam int DRAIN_WAIT  = 8;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum {FRAME_OK, FRAME_BAD_SUM, FRAME_BAD_TAIL} t_frame_flaw;

    class frame_scoreboard;
        t_pos       pos;
        logic [7:0] pay[PAYLOAD_BYTES];
        logic [7:0] xsum;
        t_result    expq[$];
        int         errors;

        function new();
            pos    = POS_HDR0;
            xsum   = 8'h00;
            errors = 0;
            foreach (pay[k]) pay[k] = 8'h00;
        endfunction

        function int pending();
            return expq.size();
        endfunction

        function void note_byte(logic [7:0] b);
            t_result    r;
            logic [7:0] want;
            r      = '0;
            r.emit = 1'b1;
            if (pos < POS_PAY0) begin
                want = (pos == POS_HDR0) ? HDR_FIRST : HDR_SECOND;
                if (b != want) begin
                    pos = POS_HDR0;
                end else begin
                    pos  = pos + t_pos'(1);
                    xsum = 8'h00;
                end
            end else if (pos < POS_CHECK) begin
                pay[pos - POS_PAY0] = b;
                xsum = xsum ^ b;
                pos  = pos + t_pos'(1);
            end else if (pos == POS_CHECK) begin
                if (xsum != b) begin
                    pos      = POS_HDR0;
                    r.status = ST_CSUM;
                    expq.push_back(r);
                end else begin
                    pos = pos + t_pos'(1);
                end
            end else begin
                // tail, and any position past it
                pos = POS_HDR0;
                if (b != TAIL_MARK) begin
                    r.status = ST_TAIL;
                end else begin
                    r.status       = ST_GOOD;
                    r.flow_x       = {pay[1], pay[0]};
                    r.flow_y       = {pay[3], pay[2]};
                    r.span_us      = {pay[5], pay[4]};
                    r.ground_dist  = {pay[7], pay[6]};
                    r.valid_code   = pay[8];
                    r.version_code = pay[9];
                    r.usable       = (pay[8] != 8'h00);
                end
                expq.push_back(r);
            end
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s got %h want %h", name, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            if (expq.size() == 0) begin
                report("result with no frame outcome pending");
            end else begin
                want = expq.pop_front();
                check_field("status", 16'(got.status), 16'(want.status));
                check_field("flow_x", got.flow_x, want.flow_x);
                check_field("flow_y", got.flow_y, want.flow_y);
                check_field("span_us", got.span_us, want.span_us);
                check_field("ground_dist", got.ground_dist, want.ground_dist);
                check_field("valid_code", 16'(got.valid_code), 16'(want.valid_code));
                check_field("version_code", 16'(got.version_code), 16'(want.version_code));
                check_field("usable", 16'(got.usable), 16'(want.usable));
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n   = 1'b0;
    logic               i_valid   = 1'b0;
    logic [7:0]         i_rx_byte = 8'h00;
    logic               i_stall   = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [1:0]         o_status;
    logic signed [15:0] o_flow_x;
    logic signed [15:0] o_flow_y;
    logic [15:0]        o_span_us;
    logic [15:0]        o_ground_dist;
    logic [7:0]         o_valid_code;
    logic [7:0]         o_version_code;
    logic               o_usable;

    frame_scoreboard sb = new();

    int         cycles      = 0;
    int         hold_reqs   = 0;
    int         hold_seen   = 0;
    int         hold_left   = 0;
    int         burst_left  = 0;
    int         frame_bytes = 0;
    int         frames      = 0;
    bit         steady      = 1'b0;
    logic [7:0] pay_buf[PAYLOAD_BYTES];

    optical_flow_frame_parser uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_flow_x       (o_flow_x),
        .o_flow_y       (o_flow_y),
        .o_span_us      (o_span_us),
        .o_ground_dist  (o_ground_dist),
        .o_valid_code   (o_valid_code),
        .o_version_code (o_version_code),
        .o_usable       (o_usable)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side stall pattern, with a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= LONG_HOLD;
            i_stall   <= 1'b1;
        end else begin
            case ((cycles / 256) % 4)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 9) < 3);
                2: i_stall <= ($urandom_range(0, 9) < 7);
                default: i_stall <= ((cycles % 5) < 2);
            endcase
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result got;
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.note_byte(i_rx_byte);
            if (o_valid && !i_stall) begin
                got              = '0;
                got.emit         = 1'b1;
                got.status       = t_status'(o_status);
                got.flow_x       = o_flow_x;
                got.flow_y       = o_flow_y;
                got.span_us      = o_span_us;
                got.ground_dist  = o_ground_dist;
                got.valid_code   = o_valid_code;
                got.version_code = o_version_code;
                got.usable       = o_usable;
                sb.check_result(got);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (steady)
                gap = 0;
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic fill_random_payload();
        for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            case ($urandom_range(0, 7))
                0: pay_buf[k] = 8'h00;
                1: pay_buf[k] = 8'hFF;
                2: pay_buf[k] = 8'h80;
                3: pay_buf[k] = 8'h7F;
                default: pay_buf[k] = 8'($urandom);
            endcase
        end
        case ($urandom_range(0, 4))
            0: pay_buf[8] = 8'h00;
            1, 2: pay_buf[8] = 8'hF5;
            default: pay_buf[8] = 8'($urandom);
        endcase
    endtask

    task automatic send_frame(input t_frame_flaw flaw, input logic [7:0] twist);
        logic [7:0] sum;
        sum = 8'h00;
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        for (int k = 0; k < PAYLOAD_BYTES; k++) begin
            send_byte(pay_buf[k]);
            sum = sum ^ pay_buf[k];
        end
        if (flaw == FRAME_BAD_SUM) begin
            send_byte(sum ^ twist);
            frame_bytes += 13;
        end else begin
            send_byte(sum);
            send_byte((flaw == FRAME_BAD_TAIL) ? (TAIL_MARK ^ twist) : TAIL_MARK);
            frame_bytes += 14;
        end
    endtask

    initial begin : stimulus
        int         pick;
        logic [7:0] b;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // second header byte wrong: the repeated 0xfe is not taken as a new start
        send_byte(HDR_FIRST);
        send_byte(HDR_FIRST);
        // field extremes, checksum with top bit set
        pay_buf = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hF5, 8'h7F};
        send_frame(FRAME_OK, 8'h00);
        // checksum mismatch, zero payload
        foreach (pay_buf[k]) pay_buf[k] = 8'h00;
        send_frame(FRAME_BAD_SUM, 8'h80);
        frame_bytes += 2;

        while (frame_bytes < ITEM_TARGET) begin
            frames++;
            if (frames == 8) begin
                hold_reqs <= hold_reqs + 1;
                steady = 1'b1;
            end
            if (frames == 14)
                steady = 1'b0;
            if (frames == 30)
                drain();
            if (frames >= 40 && frames < 46)
                steady = 1'b1;
            if (frames == 46)
                steady = 1'b0;
            fill_random_payload();
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
                send_frame(FRAME_OK, 8'h00);
            end else if (pick < 15) begin
                send_frame(FRAME_BAD_SUM, 8'($urandom_range(1, 255)));
            end else if (pick < 18) begin
                send_frame(FRAME_BAD_TAIL, 8'($urandom_range(1, 255)));
            end else if (pick == 18) begin
                b = 8'($urandom);
                if (b == HDR_SECOND)
                    b = HDR_FIRST;
                send_byte(HDR_FIRST);
                send_byte(b);
                frame_bytes += 2;
            end else begin
                pick = $urandom_range(1, 5);
                repeat (pick) send_byte(8'($urandom));
                frame_bytes += pick;
            end
        end

        drain();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== optical_flow_frame_parser.f =====
hw/rtl/ofp_pkg.sv
hw/rtl/ofp_in_stage.sv
hw/rtl/ofp_parser.sv
hw/rtl/ofp_out_stage.sv
hw/rtl/optical_flow_frame_parser.sv
sim/tb_top.sv
